@@ rtl/kne_pkg.sv @@
// ----------------------------------------------------------------------------
// kne_pkg
// shared types, constants and the twiddle table of the ntt engine
// ----------------------------------------------------------------------------
`default_nettype none

package kne_pkg;

  localparam int CoeffCount = 256;
  localparam int AddrW      = $clog2(CoeffCount);
  localparam int CoeffW     = 16;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic signed [15:0] Q_MOD     = 16'sd3329;
  localparam logic signed [15:0] Q_INV_NEG = -16'sd3327;
  localparam logic signed [15:0] INV_SCALE = 16'sd1441;
  localparam logic signed [15:0] BARRETT_V = 16'sd20159;
  localparam logic signed [32:0] BARRETT_ROUND = 33'sd33554432;

  typedef struct packed {
    logic adv;
    logic inv;
    logic scale;
  } bfly_ctrl_t;

  function automatic logic signed [15:0] zeta(input logic [6:0] k);
    logic signed [15:0] z;
    unique case (k)
      7'd0: z = -16'sd1044;   7'd1: z = -16'sd758;    7'd2: z = -16'sd359;
      7'd3: z = -16'sd1517;   7'd4: z = 16'sd1493;    7'd5: z = 16'sd1422;
      7'd6: z = 16'sd287;     7'd7: z = 16'sd202;     7'd8: z = -16'sd171;
      7'd9: z = 16'sd622;     7'd10: z = 16'sd1577;   7'd11: z = 16'sd182;
      7'd12: z = 16'sd962;    7'd13: z = -16'sd1202;  7'd14: z = -16'sd1474;
      7'd15: z = 16'sd1468;   7'd16: z = 16'sd573;    7'd17: z = -16'sd1325;
      7'd18: z = 16'sd264;    7'd19: z = 16'sd383;    7'd20: z = -16'sd829;
      7'd21: z = 16'sd1458;   7'd22: z = -16'sd1602;  7'd23: z = -16'sd130;
      7'd24: z = -16'sd681;   7'd25: z = 16'sd1017;   7'd26: z = 16'sd732;
      7'd27: z = 16'sd608;    7'd28: z = -16'sd1542;  7'd29: z = 16'sd411;
      7'd30: z = -16'sd205;   7'd31: z = -16'sd1571;  7'd32: z = 16'sd1223;
      7'd33: z = 16'sd652;    7'd34: z = -16'sd552;   7'd35: z = 16'sd1015;
      7'd36: z = -16'sd1293;  7'd37: z = 16'sd1491;   7'd38: z = -16'sd282;
      7'd39: z = -16'sd1544;  7'd40: z = 16'sd516;    7'd41: z = -16'sd8;
      7'd42: z = -16'sd320;   7'd43: z = -16'sd666;   7'd44: z = -16'sd1618;
      7'd45: z = -16'sd1162;  7'd46: z = 16'sd126;    7'd47: z = 16'sd1469;
      7'd48: z = -16'sd853;   7'd49: z = -16'sd90;    7'd50: z = -16'sd271;
      7'd51: z = 16'sd830;    7'd52: z = 16'sd107;    7'd53: z = -16'sd1421;
      7'd54: z = -16'sd247;   7'd55: z = -16'sd951;   7'd56: z = -16'sd398;
      7'd57: z = 16'sd961;    7'd58: z = -16'sd1508;  7'd59: z = -16'sd725;
      7'd60: z = 16'sd448;    7'd61: z = -16'sd1065;  7'd62: z = 16'sd677;
      7'd63: z = -16'sd1275;  7'd64: z = -16'sd1103;  7'd65: z = 16'sd430;
      7'd66: z = 16'sd555;    7'd67: z = 16'sd843;    7'd68: z = -16'sd1251;
      7'd69: z = 16'sd871;    7'd70: z = 16'sd1550;   7'd71: z = 16'sd105;
      7'd72: z = 16'sd422;    7'd73: z = 16'sd587;    7'd74: z = 16'sd177;
      7'd75: z = -16'sd235;   7'd76: z = -16'sd291;   7'd77: z = -16'sd460;
      7'd78: z = 16'sd1574;   7'd79: z = 16'sd1653;   7'd80: z = -16'sd246;
      7'd81: z = 16'sd778;    7'd82: z = 16'sd1159;   7'd83: z = -16'sd147;
      7'd84: z = -16'sd777;   7'd85: z = 16'sd1483;   7'd86: z = -16'sd602;
      7'd87: z = 16'sd1119;   7'd88: z = -16'sd1590;  7'd89: z = 16'sd644;
      7'd90: z = -16'sd872;   7'd91: z = 16'sd349;    7'd92: z = 16'sd418;
      7'd93: z = 16'sd329;    7'd94: z = -16'sd156;   7'd95: z = -16'sd75;
      7'd96: z = 16'sd817;    7'd97: z = 16'sd1097;   7'd98: z = 16'sd603;
      7'd99: z = 16'sd610;    7'd100: z = 16'sd1322;  7'd101: z = -16'sd1285;
      7'd102: z = -16'sd1465; 7'd103: z = 16'sd384;   7'd104: z = -16'sd1215;
      7'd105: z = -16'sd136;  7'd106: z = 16'sd1218;  7'd107: z = -16'sd1335;
      7'd108: z = -16'sd874;  7'd109: z = 16'sd220;   7'd110: z = -16'sd1187;
      7'd111: z = -16'sd1659; 7'd112: z = -16'sd1185; 7'd113: z = -16'sd1530;
      7'd114: z = -16'sd1278; 7'd115: z = 16'sd794;   7'd116: z = -16'sd1510;
      7'd117: z = -16'sd854;  7'd118: z = -16'sd870;  7'd119: z = 16'sd478;
      7'd120: z = -16'sd108;  7'd121: z = -16'sd308;  7'd122: z = 16'sd996;
      7'd123: z = 16'sd991;   7'd124: z = 16'sd958;   7'd125: z = -16'sd1460;
      7'd126: z = 16'sd1522;  7'd127: z = 16'sd1628;
      default: z = 16'sd0;
    endcase
    return z;
  endfunction

endpackage

`default_nettype wire

@@ rtl/kyber_ntt_engine.sv @@
// ----------------------------------------------------------------------------
// kyber_ntt_engine
// 256-point kyber ntt over q = 3329 on an in-place coefficient memory
// ----------------------------------------------------------------------------
// usage: transactions enter on in_valid/in_ready with cmd, index and value.
// a write stores value at index on acceptance and returns nothing. a read
// passes through S_RDOUT, which registers the coefficient into the output
// with done_res low once the output slot is free.
// a run transforms the whole memory in place and then returns one
// transaction with coefficient zero and done_res high. the user must write
// direction on cfg_valid/cfg_ready only while idle; the block does not
// enforce this. direction picks forward (0) or inverse (1). a run takes
// 7 layers of 128 butterflies (one read of both entries, three datapath
// stages, two writes on the single write port), plus 256 scaling steps
// for the inverse with one write each. in_ready is high only when idle.
// results sit in an output register; a stalled receiver holds the engine
// in its last step until out_ready. reset clears control and direction;
// memory contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module kyber_ntt_engine
  import kne_pkg::*;
#(
  parameter int COEFF_COUNT = CoeffCount
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire [1:0]                cmd,
  input  wire [7:0]                index,
  input  wire signed [15:0]        value,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic signed [15:0]       coefficient,
  output logic                     done_res,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire                      direction
);

  localparam int AW = $clog2(COEFF_COUNT);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDOUT = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_M1    = 3'd3;
  localparam logic [2:0] S_M2    = 3'd4;
  localparam logic [2:0] S_M3    = 3'd5;
  localparam logic [2:0] S_W0    = 3'd6;
  localparam logic [2:0] S_W1    = 3'd7;

  logic [2:0]        state;
  logic              dir;
  logic              inv;
  logic              scale;
  logic              finish;
  logic [2:0]        lg;
  logic [AW-1:0]     bcnt;
  logic [AW-1:0]     addr_lo, addr_hi;
  logic signed [15:0] zreg;

  logic              acc;
  logic              slot_free;
  logic [AW-1:0]     mask, bj, bj_hi, grp;
  logic [6:0]        kidx;
  logic              we, re;
  logic [AW-1:0]     waddr, raddr_a, raddr_b;
  logic signed [15:0] wdata, rdata_a, rdata_b, lo_res, hi_res;
  bfly_ctrl_t        bctrl;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign acc       = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    mask  = AW'((9'd1 << lg) - 9'd1);
    bj    = (AW'(bcnt << 1) & ~AW'(mask << 1)) | (bcnt & mask);
    bj_hi = bj | AW'(mask + AW'(1));
    grp   = bcnt >> lg;
    if (inv) begin
      kidx = 7'(((9'd1 << (4'd8 - 4'(lg))) - 9'd1) - 9'(grp));
    end else begin
      kidx = 7'((9'd1 << (4'd7 - 4'(lg))) + 9'(grp));
    end
  end

  always_comb begin
    re      = (acc && cmd == CMD_READ) || state == S_RD;
    raddr_a = (state == S_IDLE) ? index : (scale ? bcnt : bj);
    raddr_b = bj_hi;
    we      = 1'b0;
    waddr   = addr_lo;
    wdata   = lo_res;
    unique case (state)
      S_IDLE: begin
        we    = acc && cmd == CMD_WRITE;
        waddr = index;
        wdata = value;
      end
      S_W0: begin
        we = 1'b1;
      end
      S_W1: begin
        we    = 1'b1;
        waddr = addr_hi;
        wdata = hi_res;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign bctrl.adv   = (state == S_M1) || (state == S_M2) || (state == S_M3);
  assign bctrl.inv   = inv && !scale;
  assign bctrl.scale = scale;

  kne_coeff_mem #(.COEFF_COUNT(COEFF_COUNT)) u_mem (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (re),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  kne_butterfly u_bfly (
    .clk    (clk),
    .ctrl   (bctrl),
    .a      (rdata_a),
    .b      (rdata_b),
    .z      (zreg),
    .lo_res (lo_res),
    .hi_res (hi_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dir <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      dir <= direction;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RD) begin
      addr_lo <= scale ? bcnt : bj;
      addr_hi <= scale ? bcnt : bj_hi;
      zreg    <= scale ? INV_SCALE : zeta(kidx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      inv       <= 1'b0;
      scale     <= 1'b0;
      finish    <= 1'b0;
      lg        <= 3'd0;
      bcnt      <= '0;
    end else begin
      if (out_valid && out_ready && state != S_RDOUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc && cmd == CMD_READ) begin
            finish <= 1'b0;
            state  <= S_RDOUT;
          end else if (acc && cmd == CMD_RUN) begin
            inv   <= dir;
            scale <= 1'b0;
            lg    <= dir ? 3'd1 : 3'd7;
            bcnt  <= '0;
            state <= S_RD;
          end
        end
        S_RDOUT: begin
          if (slot_free) begin
            out_valid   <= 1'b1;
            coefficient <= finish ? 16'sd0 : rdata_a;
            done_res    <= finish;
            state       <= S_IDLE;
          end
        end
        S_RD: state <= S_M1;
        S_M1: state <= S_M2;
        S_M2: state <= S_M3;
        S_M3: state <= scale ? S_W1 : S_W0;
        S_W0: state <= S_W1;
        S_W1: begin
          if (scale) begin
            if (bcnt == AW'(COEFF_COUNT - 1)) begin
              finish <= 1'b1;
              state  <= S_RDOUT;
            end else begin
              bcnt  <= bcnt + AW'(1);
              state <= S_RD;
            end
          end else if (bcnt == AW'(COEFF_COUNT / 2 - 1)) begin
            bcnt <= '0;
            if (!inv && lg == 3'd1) begin
              finish <= 1'b1;
              state  <= S_RDOUT;
            end else if (inv && lg == 3'd7) begin
              scale <= 1'b1;
              state <= S_RD;
            end else begin
              lg    <= inv ? lg + 3'd1 : lg - 3'd1;
              state <= S_RD;
            end
          end else begin
            bcnt  <= bcnt + AW'(1);
            state <= S_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/kne_coeff_mem.sv @@
// ----------------------------------------------------------------------------
// kne_coeff_mem
// coefficient memory, one write port and two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module kne_coeff_mem
  import kne_pkg::*;
#(
  parameter int COEFF_COUNT = CoeffCount
) (
  input  wire                             clk,
  input  wire                             we,
  input  wire [$clog2(COEFF_COUNT)-1:0]   waddr,
  input  wire signed [CoeffW-1:0]         wdata,
  input  wire                             re,
  input  wire [$clog2(COEFF_COUNT)-1:0]   raddr_a,
  input  wire [$clog2(COEFF_COUNT)-1:0]   raddr_b,
  output logic signed [CoeffW-1:0]        rdata_a,
  output logic signed [CoeffW-1:0]        rdata_b
);

  logic signed [CoeffW-1:0] mem [COEFF_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

@@ rtl/kne_butterfly.sv @@
// ----------------------------------------------------------------------------
// kne_butterfly
// three-stage butterfly datapath: montgomery multiply and barrett reduction
// ----------------------------------------------------------------------------
`default_nettype none

module kne_butterfly
  import kne_pkg::*;
(
  input  wire                       clk,
  input  wire bfly_ctrl_t           ctrl,
  input  wire signed [CoeffW-1:0]   a,
  input  wire signed [CoeffW-1:0]   b,
  input  wire signed [CoeffW-1:0]   z,
  output logic signed [CoeffW-1:0]  lo_res,
  output logic signed [CoeffW-1:0]  hi_res
);

  logic signed [15:0] s1_a, s1_sum;
  logic signed [31:0] s1_prod, s1_bprod;
  logic signed [15:0] s2_a, s2_sum, s2_t16;
  logic signed [31:0] s2_prod;
  logic signed [5:0]  s2_bq;

  logic signed [15:0] diff, sum, oper;
  logic signed [15:0] lo16, mred;
  logic signed [32:0] dval, bsum;
  logic signed [31:0] tq_full;
  logic signed [15:0] tq;

  always_comb begin
    sum  = 16'(a + b);
    diff = 16'(b - a);
    oper = ctrl.scale ? a : (ctrl.inv ? diff : b);
  end

  // stage 1: product and barrett estimate product
  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      s1_a     <= a;
      s1_sum   <= sum;
      s1_prod  <= z * oper;
      s1_bprod <= BARRETT_V * sum;
    end
  end

  // stage 2: montgomery factor and barrett quotient
  always_comb begin
    lo16 = s1_prod[15:0];
    bsum = 33'(s1_bprod) + BARRETT_ROUND;
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      s2_a    <= s1_a;
      s2_sum  <= s1_sum;
      s2_prod <= s1_prod;
      s2_t16  <= 16'(lo16 * Q_INV_NEG);
      s2_bq   <= bsum[31:26];
    end
  end

  // stage 3: reduce and combine
  always_comb begin
    dval    = 33'(s2_prod) - 33'(s2_t16) * 33'(Q_MOD);
    mred    = dval[31:16];
    tq_full = 32'(s2_bq) * 32'(Q_MOD);
    tq      = tq_full[15:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      if (ctrl.inv) begin
        lo_res <= 16'(s2_sum - tq);
        hi_res <= mred;
      end else begin
        lo_res <= 16'(s2_a + mred);
        hi_res <= ctrl.scale ? mred : 16'(s2_a - mred);
      end
    end
  end

endmodule

`default_nettype wire
